@@ hdl/parameter_tween_generator_top_macros.svh @@
// ----------------------------------------------------------------------------
// tween generator assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef PARAMETER_TWEEN_GENERATOR_TOP_MACROS_SVH
`define PARAMETER_TWEEN_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PTG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tween generator check failed");

// next-cycle implication
`define PTG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tween generator check failed");

`else

`define PTG_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define PTG_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/ptg_pkg.sv @@
// ----------------------------------------------------------------------------
// ptg_pkg
// shared types, codes and the cosine table builder of the tween generator
// ----------------------------------------------------------------------------
`default_nettype none

package ptg_pkg;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CURVE,
      ST_ROM,
      ST_MUL,
      ST_DONE
   } ptg_state_type;

   // status of a multi-cycle unit
   typedef struct packed {
      logic busy;
      logic done;
   } ptg_unit_sts_type;

   // loop modes
   localparam logic [1:0] LOOP_ONCE     = 2'd0;
   localparam logic [1:0] LOOP_REPEAT   = 2'd1;
   localparam logic [1:0] LOOP_PINGPONG = 2'd2;

   // curve kinds
   localparam logic [1:0] CURVE_STEP   = 2'd0;
   localparam logic [1:0] CURVE_LINEAR = 2'd1;
   localparam logic [1:0] CURVE_COSINE = 2'd2;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOOP_MODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CURVE_KIND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_END        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DURATION   = 3'd4;

   // field widths
   localparam int DELTA_W    = 16;
   localparam int VALUE_W    = 32;
   localparam int ELAPSED_W  = 32;
   localparam int DUR_W      = 24;
   localparam int WEIGHT_W   = 17;
   localparam int FRAC_W     = 18;
   localparam int RSP_DATA_W = 40;

   // landmarks with 16 fraction bits (q1.16, q2.16)
   localparam logic [WEIGHT_W-1:0] ONE_Q16  = 17'd65536;
   localparam logic [WEIGHT_W-1:0] HALF_Q16 = 17'd32768;
   localparam logic [FRAC_W-1:0]   TWO_Q16  = 18'd131072;

   // divider runs two quotient bits per step: 16 remainder steps, 9 fraction steps
   localparam int DIV_STEPS = 25;
   // booth radix-4 multiplier over an 18-bit padded weight
   localparam int MUL_STEPS = 9;

   localparam logic [63:0] ANGLE_Q28 = 64'd842887332;

   // one entry of the raised cosine table, evaluated at elaboration
   function automatic logic [16:0] cos_entry(input int unsigned bits, input int unsigned j);
      logic [63:0]        a;
      logic [63:0]        a2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] e;
      int unsigned        k;
      a    = (64'((1 << bits) - j) * ANGLE_Q28) >> bits;
      a2   = (a * a) >> 28;
      term = 64'd1 << 28;
      sum  = $signed(term);
      for (k = 1; k <= 24; k++) begin
         term = ((term * a2) >> 28) / 64'((2 * k - 1) * (2 * k));
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      e = sum + 64'sd268435456 + 64'sd4096;
      if (e < 0) begin
         e = '0;
      end
      e = e >>> 13;
      if (e > 64'sd65536) begin
         e = 64'sd65536;
      end
      return e[16:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/ptg_divider.sv @@
// ----------------------------------------------------------------------------
// ptg_divider
// radix-4 restoring divider: remainder of the count, then an 18-bit fraction
// ----------------------------------------------------------------------------
`default_nettype none

module ptg_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ptg_pkg::ELAPSED_W-1:0]     dividend,
   input  wire logic [ptg_pkg::DUR_W-1:0]         divisor,
   output ptg_pkg::ptg_unit_sts_type              sts,
   output logic [ptg_pkg::FRAC_W-1:0]             frac
);

   localparam int CntW = $clog2(ptg_pkg::DIV_STEPS);

   logic [ptg_pkg::ELAPSED_W-1:0] dvd_ff, dvd_in;
   logic [ptg_pkg::DUR_W-1:0]     rem_ff, rem_in;
   logic [ptg_pkg::DUR_W-1:0]     div_ff, div_in;
   logic [ptg_pkg::FRAC_W-1:0]    quo_ff, quo_in;
   logic [CntW-1:0]               cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   logic [ptg_pkg::DUR_W-1:0]     rem_t;
   logic [ptg_pkg::ELAPSED_W-1:0] dvd_t;
   logic [ptg_pkg::FRAC_W-1:0]    quo_t;
   logic [ptg_pkg::DUR_W:0]       trial;

   // two dependent restoring steps per cycle
   always_comb begin
      rem_t = rem_ff;
      dvd_t = dvd_ff;
      quo_t = quo_ff;
      trial = '0;
      for (int i = 0; i < 2; i++) begin
         trial = {rem_t, dvd_t[ptg_pkg::ELAPSED_W-1]};
         if (trial >= {1'b0, div_ff}) begin
            rem_t = ptg_pkg::DUR_W'(trial - {1'b0, div_ff});
            quo_t = {quo_t[ptg_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_t = trial[ptg_pkg::DUR_W-1:0];
            quo_t = {quo_t[ptg_pkg::FRAC_W-2:0], 1'b0};
         end
         dvd_t = {dvd_t[ptg_pkg::ELAPSED_W-2:0], 1'b0};
      end
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_t;
         rem_in = rem_t;
         quo_in = quo_t;
         cnt_in = CntW'(cnt_ff + 1'b1);
         if (cnt_ff == CntW'(ptg_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign frac     = quo_ff;

endmodule

`default_nettype wire

@@ hdl/ptg_blend.sv @@
// ----------------------------------------------------------------------------
// ptg_blend
// start + floor((end - start) * weight / 65536), booth radix-4 serial multiply
// ----------------------------------------------------------------------------
`default_nettype none

module ptg_blend (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ptg_pkg::VALUE_W-1:0]       start_value,
   input  wire logic [ptg_pkg::VALUE_W-1:0]       end_value,
   input  wire logic [ptg_pkg::WEIGHT_W-1:0]      weight,
   output ptg_pkg::ptg_unit_sts_type              sts,
   output logic [ptg_pkg::VALUE_W-1:0]            result
);

   localparam int RangeW = ptg_pkg::VALUE_W + 1;
   localparam int AccW   = RangeW + ptg_pkg::WEIGHT_W;
   localparam int WsrW   = ptg_pkg::WEIGHT_W + 2;
   localparam int CntW   = $clog2(ptg_pkg::MUL_STEPS);

   logic [RangeW-1:0]              range_ff, range_in;
   logic [WsrW-1:0]                wsr_ff, wsr_in;
   logic [AccW-1:0]                acc_ff, acc_in;
   logic [CntW-1:0]                cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           fin_ff, fin_in;
   logic                           done_ff, done_in;
   logic [ptg_pkg::VALUE_W-1:0]    result_ff, result_in;

   logic [2:0]                     digit;
   logic [AccW-1:0]                mag;
   logic                           neg;
   logic [AccW-1:0]                range_ext;

   assign range_ext = {{(AccW-RangeW){range_ff[RangeW-1]}}, range_ff};
   assign digit     = wsr_ff[WsrW-1 -: 3];

   // booth recoding of the top weight bits
   always_comb begin
      mag = '0;
      neg = 1'b0;
      case (digit)
         3'b001, 3'b010: begin
            mag = range_ext;
         end
         3'b011: begin
            mag = {range_ext[AccW-2:0], 1'b0};
         end
         3'b100: begin
            mag = {range_ext[AccW-2:0], 1'b0};
            neg = 1'b1;
         end
         3'b101, 3'b110: begin
            mag = range_ext;
            neg = 1'b1;
         end
         default: begin
            mag = '0;
         end
      endcase
   end

   always_comb begin
      range_in  = range_ff;
      wsr_in    = wsr_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         range_in = {end_value[ptg_pkg::VALUE_W-1], end_value}
                  - {start_value[ptg_pkg::VALUE_W-1], start_value};
         wsr_in   = {1'b0, weight, 1'b0};
         acc_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[AccW-3:0], 2'b00} + (mag ^ {AccW{neg}}) + AccW'(neg);
         wsr_in = {wsr_ff[WsrW-3:0], 2'b00};
         cnt_in = CntW'(cnt_ff + 1'b1);
         if (cnt_ff == CntW'(ptg_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // product shifted down by 16, floor for both signs
         result_in = start_value + acc_ff[ptg_pkg::VALUE_W+15:16];
         done_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      range_ff  <= range_in;
      wsr_ff    <= wsr_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign sts.busy = busy_ff | fin_ff;
   assign sts.done = done_ff;
   assign result   = result_ff;

endmodule

`default_nettype wire

@@ hdl/ptg_cos_rom.sv @@
// ----------------------------------------------------------------------------
// ptg_cos_rom
// raised cosine ease table with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ptg_cos_rom #(
   parameter int TABLE_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic [TABLE_BITS:0]           idx,
   output logic [ptg_pkg::WEIGHT_W-1:0]       data
);

   localparam int TabSize = (1 << TABLE_BITS) + 1;

   logic [ptg_pkg::WEIGHT_W-1:0] rom_w [TabSize];
   logic [ptg_pkg::WEIGHT_W-1:0] data_ff;

   for (genvar j = 0; j < TabSize; j++) begin : g_entry
      assign rom_w[j] = ptg_pkg::cos_entry(TABLE_BITS, j);
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_w[idx];
   end

   assign data = data_ff;

endmodule

`default_nettype wire

@@ hdl/parameter_tween_generator_top.sv @@
// ----------------------------------------------------------------------------
// parameter_tween_generator_top
// tween generator: elapsed counter, loop progress and eased value per tick
//
//   channel  direction  contents
//   req_     in         tdata[15:0] tick_delta
//   rsp_     out        tdata[31:0] current_out, [32] still_running
//   csr_     in         index 0 loop, 1 curve, 2 start, 3 end, 4 duration
//
// an item runs the serial divider (25 steps of two bits) and then, with the linear
// or cosine curve, the radix-4 multiplier (9 steps plus a final add); the cosine
// curve adds a table read first, and step or an unknown curve skips the multiplier
// once the animation has stopped an item skips the divider and sends the held value
// reset is synchronous, active high; it restores the register defaults
// a finished result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
`default_nettype none

`include "parameter_tween_generator_top_macros.svh"

module parameter_tween_generator_top #(
   parameter int COS_TABLE_BITS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // tick channel
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [ptg_pkg::DELTA_W-1:0]            req_tdata,   // tick_delta
   // result channel
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [ptg_pkg::RSP_DATA_W-1:0]              rsp_tdata,   // current_out, still_running
   // register writes
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [ptg_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [ptg_pkg::VALUE_W-1:0]            csr_data
);

   // configuration registers
   logic [1:0]                     loop_mode_ff, loop_mode_in;
   logic [1:0]                     curve_kind_ff, curve_kind_in;
   logic [ptg_pkg::VALUE_W-1:0]    start_value_ff, start_value_in;
   logic [ptg_pkg::VALUE_W-1:0]    end_value_ff, end_value_in;
   logic [ptg_pkg::DUR_W-1:0]      duration_ff, duration_in;

   // animation state
   logic [ptg_pkg::ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic                           running_ff, running_in;
   logic [ptg_pkg::VALUE_W-1:0]    held_ff, held_in;
   logic [ptg_pkg::WEIGHT_W-1:0]   w_ff, w_in;
   ptg_pkg::ptg_state_type         state_ff, state_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ptg_pkg::VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                           rsp_run_ff, rsp_run_in;

   // handshakes
   logic                           req_fire;
   logic                           rsp_fire;
   logic                           csr_fire;

   // datapath helpers
   logic [ptg_pkg::DUR_W-1:0]      dur_eff;
   logic [ptg_pkg::ELAPSED_W:0]    elapsed_sum;
   logic [ptg_pkg::ELAPSED_W-1:0]  elapsed_sat;
   logic                           div_start;
   logic                           blend_start;
   ptg_pkg::ptg_unit_sts_type      div_sts;
   ptg_pkg::ptg_unit_sts_type      blend_sts;
   logic [ptg_pkg::FRAC_W-1:0]     frac;
   logic [ptg_pkg::WEIGHT_W-1:0]   half_q;
   logic [ptg_pkg::FRAC_W-1:0]     mirror;
   logic [ptg_pkg::WEIGHT_W-1:0]   w_calc;
   logic                           stop_now;
   logic [ptg_pkg::WEIGHT_W-1:0]   rom_data;
   logic [ptg_pkg::WEIGHT_W-1:0]   blend_weight;
   logic [ptg_pkg::VALUE_W-1:0]    blend_result;

   assign req_tready = (state_ff == ptg_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;
   assign csr_fire   = csr_valid & csr_ready;

   // a zero duration behaves as one tick
   assign dur_eff = (duration_ff == '0) ? ptg_pkg::DUR_W'(1) : duration_ff;

   // saturating elapsed counter
   assign elapsed_sum = {1'b0, elapsed_ff} + (ptg_pkg::ELAPSED_W + 1)'(req_tdata);
   assign elapsed_sat = elapsed_sum[ptg_pkg::ELAPSED_W] ? '1
                                                        : elapsed_sum[ptg_pkg::ELAPSED_W-1:0];

   // frac is floor(r * 2^18 / d) with r the remainder of the count
   ptg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed_sat),
      .divisor  (dur_eff),
      .sts      (div_sts),
      .frac     (frac)
   );

   // progress per loop mode
   assign half_q = frac[ptg_pkg::FRAC_W-1:1];
   assign mirror = ptg_pkg::TWO_Q16 - {1'b0, half_q};

   always_comb begin
      w_calc   = '0;
      stop_now = 1'b0;
      case (loop_mode_ff)
         ptg_pkg::LOOP_ONCE: begin
            if (elapsed_ff >= ptg_pkg::ELAPSED_W'(dur_eff)) begin
               w_calc   = ptg_pkg::ONE_Q16;
               stop_now = 1'b1;
            end else begin
               w_calc = {1'b0, frac[ptg_pkg::FRAC_W-1:2]};
            end
         end
         ptg_pkg::LOOP_REPEAT: begin
            w_calc = {1'b0, frac[ptg_pkg::FRAC_W-1:2]};
         end
         ptg_pkg::LOOP_PINGPONG: begin
            // reflect the second half of the pass
            if (half_q > ptg_pkg::ONE_Q16) begin
               w_calc = mirror[ptg_pkg::WEIGHT_W-1:0];
            end else begin
               w_calc = half_q;
            end
         end
         default: begin
            w_calc = '0;
         end
      endcase
   end

   // table index is the top bits of the progress
   ptg_cos_rom #(
      .TABLE_BITS (COS_TABLE_BITS)
   ) u_cos_rom (
      .clock (clock),
      .idx   (w_ff[ptg_pkg::WEIGHT_W-1 -: COS_TABLE_BITS + 1]),
      .data  (rom_data)
   );

   assign blend_weight = (state_ff == ptg_pkg::ST_ROM) ? rom_data : w_ff;

   ptg_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .start       (blend_start),
      .start_value (start_value_ff),
      .end_value   (end_value_ff),
      .weight      (blend_weight),
      .sts         (blend_sts),
      .result      (blend_result)
   );

   // sequencer: next state, unit starts and register updates
   always_comb begin
      state_in       = state_ff;
      loop_mode_in   = loop_mode_ff;
      curve_kind_in  = curve_kind_ff;
      start_value_in = start_value_ff;
      end_value_in   = end_value_ff;
      duration_in    = duration_ff;
      elapsed_in     = elapsed_ff;
      running_in     = running_ff;
      held_in        = held_ff;
      w_in           = w_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_run_in     = rsp_run_ff;
      div_start      = 1'b0;
      blend_start    = 1'b0;

      case (state_ff)
         ptg_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (running_ff) begin
                  elapsed_in = elapsed_sat;
                  div_start  = 1'b1;
                  state_in   = ptg_pkg::ST_DIV;
               end else begin
                  // stopped: answer with the held value
                  state_in = ptg_pkg::ST_DONE;
               end
            end
         end
         ptg_pkg::ST_DIV: begin
            if (div_sts.done) begin
               w_in = w_calc;
               if (stop_now) begin
                  running_in = 1'b0;
               end
               state_in = ptg_pkg::ST_CURVE;
            end
         end
         ptg_pkg::ST_CURVE: begin
            case (curve_kind_ff)
               ptg_pkg::CURVE_STEP: begin
                  held_in  = (w_ff < ptg_pkg::HALF_Q16) ? start_value_ff : end_value_ff;
                  state_in = ptg_pkg::ST_DONE;
               end
               ptg_pkg::CURVE_LINEAR: begin
                  blend_start = 1'b1;
                  state_in    = ptg_pkg::ST_MUL;
               end
               ptg_pkg::CURVE_COSINE: begin
                  // table read lands next cycle
                  state_in = ptg_pkg::ST_ROM;
               end
               default: begin
                  // unknown curve keeps the held value
                  state_in = ptg_pkg::ST_DONE;
               end
            endcase
         end
         ptg_pkg::ST_ROM: begin
            blend_start = 1'b1;
            state_in    = ptg_pkg::ST_MUL;
         end
         ptg_pkg::ST_MUL: begin
            if (blend_sts.done) begin
               held_in  = blend_result;
               state_in = ptg_pkg::ST_DONE;
            end
         end
         ptg_pkg::ST_DONE: begin
            // load the output register once it is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = held_ff;
               rsp_run_in   = running_ff;
               state_in     = ptg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptg_pkg::ST_IDLE;
         end
      endcase

      // register write restarts the animation, held value stays
      if (csr_fire) begin
         case (csr_index)
            ptg_pkg::REG_LOOP_MODE: begin
               loop_mode_in = csr_data[1:0];
               elapsed_in   = '0;
               running_in   = 1'b1;
            end
            ptg_pkg::REG_CURVE_KIND: begin
               curve_kind_in = csr_data[1:0];
               elapsed_in    = '0;
               running_in    = 1'b1;
            end
            ptg_pkg::REG_START: begin
               start_value_in = csr_data;
               elapsed_in     = '0;
               running_in     = 1'b1;
            end
            ptg_pkg::REG_END: begin
               end_value_in = csr_data;
               elapsed_in   = '0;
               running_in   = 1'b1;
            end
            ptg_pkg::REG_DURATION: begin
               duration_in = csr_data[ptg_pkg::DUR_W-1:0];
               elapsed_in  = '0;
               running_in  = 1'b1;
            end
            default: begin
               // index beyond the register list is ignored
               elapsed_in = elapsed_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ptg_pkg::ST_IDLE;
         loop_mode_ff   <= ptg_pkg::LOOP_ONCE;
         curve_kind_ff  <= ptg_pkg::CURVE_LINEAR;
         start_value_ff <= '0;
         end_value_ff   <= '0;
         duration_ff    <= ptg_pkg::DUR_W'(1);
         elapsed_ff     <= '0;
         running_ff     <= 1'b1;
         held_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         loop_mode_ff   <= loop_mode_in;
         curve_kind_ff  <= curve_kind_in;
         start_value_ff <= start_value_in;
         end_value_ff   <= end_value_in;
         duration_ff    <= duration_in;
         elapsed_ff     <= elapsed_in;
         running_ff     <= running_in;
         held_ff        <= held_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      w_ff         <= w_in;
      rsp_value_ff <= rsp_value_in;
      rsp_run_ff   <= rsp_run_in;
   end

   // result transfer: value in the low word, running flag above, zero fill
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ptg_pkg::RSP_DATA_W - ptg_pkg::VALUE_W - 1){1'b0}},
                        rsp_run_ff, rsp_value_ff};

   // divider finishes only while the sequencer waits for it
   `PTG_ASSERT_SAME(a_div_done_in_div, clock, reset, div_sts.done, state_ff == ptg_pkg::ST_DIV)
   // multiplier finishes only while the sequencer waits for it
   `PTG_ASSERT_SAME(a_mul_done_in_mul, clock, reset, blend_sts.done, state_ff == ptg_pkg::ST_MUL)
   // a stopped animation stays stopped until a register write
   `PTG_ASSERT_NEXT(a_stop_sticks, clock, reset, !running_ff && !csr_fire, !running_ff)
   // an accepted tick always leaves idle
   `PTG_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != ptg_pkg::ST_IDLE)

endmodule

`default_nettype wire
